>>> rtl/fsc_pkg.sv
// Shared widths, types, register indexes and plane field helpers for the frustum sphere cull.
`timescale 1ns / 1ps
package fsc_pkg;

   localparam int FSC_NUM_PLANES  = 6;
   localparam int FSC_PLANE_REGS  = 6;
   localparam int FSC_CSR_IDX_W   = 3;
   localparam int FSC_CSR_DATA_W  = 64;
   localparam int FSC_COORD_W     = 24;
   localparam int FSC_RADIUS_W    = 23;
   localparam int FSC_NORM_W      = 12;
   localparam int FSC_OFFS_W      = 28;
   localparam int FSC_PROD_W      = FSC_NORM_W + FSC_COORD_W;
   localparam int FSC_SUM_W       = 40;
   localparam int FSC_SCALE_SHIFT = 10;

   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_NEAR_IDX   = 3'd0;
   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_FAR_IDX    = 3'd1;
   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_LEFT_IDX   = 3'd2;
   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_RIGHT_IDX  = 3'd3;
   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_TOP_IDX    = 3'd4;
   localparam logic [FSC_CSR_IDX_W-1:0] PLANE_BOTTOM_IDX = 3'd5;

   typedef logic [FSC_CSR_DATA_W-1:0] plane_type;

   typedef struct packed {
      logic                           valid;
      logic signed [FSC_COORD_W-1:0]  cx;
      logic signed [FSC_COORD_W-1:0]  cy;
      logic signed [FSC_COORD_W-1:0]  cz;
      logic        [FSC_RADIUS_W-1:0] radius;
      logic                           in_frustum;
   } sphere_type;

   function automatic logic signed [FSC_NORM_W-1:0] plane_nx(input plane_type p);
      return $signed(p[FSC_NORM_W-1:0]);
   endfunction

   function automatic logic signed [FSC_NORM_W-1:0] plane_ny(input plane_type p);
      return $signed(p[2*FSC_NORM_W-1:FSC_NORM_W]);
   endfunction

   function automatic logic signed [FSC_NORM_W-1:0] plane_nz(input plane_type p);
      return $signed(p[3*FSC_NORM_W-1:2*FSC_NORM_W]);
   endfunction

   function automatic logic signed [FSC_OFFS_W-1:0] plane_d(input plane_type p);
      return $signed(p[FSC_CSR_DATA_W-1:3*FSC_NORM_W]);
   endfunction

endpackage

>>> rtl/fsc_cell.sv
// One plane test cell: product stage, then sum and sign stage, with its own hold logic.
`timescale 1ns / 1ps
module fsc_cell (
   input  logic               clock,
   input  logic               reset,
   input  fsc_pkg::plane_type  plane,
   input  fsc_pkg::sphere_type sphere_in,
   output fsc_pkg::sphere_type sphere_out,
   input  logic               take_next,
   output logic               take_this
);
   import fsc_pkg::*;

   sphere_type                   a_sph_ff;
   logic signed [FSC_PROD_W-1:0] a_px_ff, a_py_ff, a_pz_ff;
   logic signed [FSC_SUM_W-1:0]  a_bias_ff;
   logic signed [FSC_PROD_W-1:0] a_px_in, a_py_in, a_pz_in;
   logic signed [FSC_SUM_W-1:0]  a_bias_in;
   logic signed [FSC_SUM_W-1:0]  b_sum;
   sphere_type                   b_sph_ff;
   sphere_type                   b_sph_in;
   logic                         take_a;
   logic                         take_b;

   assign take_b    = !b_sph_ff.valid || take_next;
   assign take_a    = !a_sph_ff.valid || take_b;
   assign take_this = take_a;

   // products carry 18 fractional bits; offset and radius are brought to that scale
   always_comb begin
      a_px_in   = FSC_PROD_W'(plane_nx(plane)) * FSC_PROD_W'(sphere_in.cx);
      a_py_in   = FSC_PROD_W'(plane_ny(plane)) * FSC_PROD_W'(sphere_in.cy);
      a_pz_in   = FSC_PROD_W'(plane_nz(plane)) * FSC_PROD_W'(sphere_in.cz);
      a_bias_in = (FSC_SUM_W'(plane_d(plane))
                   + FSC_SUM_W'($signed({1'b0, sphere_in.radius}))) <<< FSC_SCALE_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_sph_ff.valid <= 1'b0;
      end else if (take_a) begin
         a_sph_ff  <= sphere_in;
         a_px_ff   <= a_px_in;
         a_py_ff   <= a_py_in;
         a_pz_ff   <= a_pz_in;
         a_bias_ff <= a_bias_in;
      end
   end

   // drop inside when distance plus radius goes negative
   always_comb begin
      b_sum = FSC_SUM_W'(a_px_ff) + FSC_SUM_W'(a_py_ff) + FSC_SUM_W'(a_pz_ff) + a_bias_ff;
      b_sph_in            = a_sph_ff;
      b_sph_in.in_frustum = a_sph_ff.in_frustum & ~b_sum[FSC_SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_sph_ff.valid <= 1'b0;
      end else if (take_b) begin
         b_sph_ff <= b_sph_in;
      end
   end

   assign sphere_out = b_sph_ff;

   a_reject_sticky: assert property (@(posedge clock) disable iff (reset)
      (take_b && a_sph_ff.valid && !a_sph_ff.in_frustum) |=> !sphere_out.in_frustum)
      else $error("rejected request became inside again");

   a_bubble_moves: assert property (@(posedge clock) disable iff (reset)
      (take_b && !a_sph_ff.valid) |=> !sphere_out.valid)
      else $error("empty slot turned into a request");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (b_sph_ff.valid && !take_next) |=> (b_sph_ff.valid && $stable(b_sph_ff.in_frustum)))
      else $error("held result changed");

endmodule

>>> rtl/frustum_sphere_cull_top.sv
// Top level of the frustum sphere cull: plane registers and the chain of plane cells.
// Usage:
//   A request on req_* carries a sphere centre and radius (8 fractional bits). It is
//   taken at a rising clock edge with req_valid high and req_stall low.
//   rsp_inside_res is 1 unless the sphere lies fully behind one of the first
//   NUM_PLANES planes (near, far, left, right, top, bottom); it is taken at an edge
//   with rsp_valid high and rsp_stall low.
//   Planes are written through csr_wen/csr_index/csr_wdata while no request is in
//   flight; indexes past the bottom plane are ignored.
// Pipeline:
//   Each cell has two register stages (products, then sum and compare), so a result
//   passes through both stages of every cell in turn before it shows on rsp_*. One
//   request is taken every cycle while req_stall is low; the chain holds up
//   to 2*NUM_PLANES requests.
// Reset: synchronous; clears all planes to zero (every sphere reads as inside) and
//   empties the chain.
// Stall: a stalled result holds on the rsp_* ports; earlier stages keep filling
//   empty slots, and req_stall rises only once every stage up to the input is full.
`timescale 1ns / 1ps
module frustum_sphere_cull_top #(
   parameter int NUM_PLANES = fsc_pkg::FSC_NUM_PLANES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fsc_pkg::FSC_COORD_W-1:0]  req_center_x,
   input  logic signed [fsc_pkg::FSC_COORD_W-1:0]  req_center_y,
   input  logic signed [fsc_pkg::FSC_COORD_W-1:0]  req_center_z,
   input  logic        [fsc_pkg::FSC_RADIUS_W-1:0] req_radius,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_inside_res,
   input  logic                                csr_wen,
   input  logic        [fsc_pkg::FSC_CSR_IDX_W-1:0]  csr_index,
   input  logic        [fsc_pkg::FSC_CSR_DATA_W-1:0] csr_wdata
);
   import fsc_pkg::*;

   plane_type  plane_ff [FSC_PLANE_REGS];
   sphere_type chain    [NUM_PLANES+1];
   logic       take     [NUM_PLANES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FSC_PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (csr_wen) begin
         case (csr_index)
            PLANE_NEAR_IDX:   plane_ff[0] <= csr_wdata;
            PLANE_FAR_IDX:    plane_ff[1] <= csr_wdata;
            PLANE_LEFT_IDX:   plane_ff[2] <= csr_wdata;
            PLANE_RIGHT_IDX:  plane_ff[3] <= csr_wdata;
            PLANE_TOP_IDX:    plane_ff[4] <= csr_wdata;
            PLANE_BOTTOM_IDX: plane_ff[5] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      chain[0].valid      = req_valid;
      chain[0].cx         = req_center_x;
      chain[0].cy         = req_center_y;
      chain[0].cz         = req_center_z;
      chain[0].radius     = req_radius;
      chain[0].in_frustum = 1'b1;
   end

   assign take[NUM_PLANES] = !rsp_stall;

   for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
      fsc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .plane      (plane_ff[g]),
         .sphere_in  (chain[g]),
         .sphere_out (chain[g+1]),
         .take_next  (take[g+1]),
         .take_this  (take[g])
      );
   end

   assign req_stall      = !take[0];
   assign rsp_valid      = chain[NUM_PLANES].valid;
   assign rsp_inside_res = chain[NUM_PLANES].in_frustum;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present right after reset");

   a_free_output_takes: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled while output stage is free");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_inside_res)))
      else $error("stalled result changed");

endmodule

>>> tb/frustum_sphere_cull_top_test.sv
// Self-checking testbench for frustum_sphere_cull_top: plane sets, sphere requests, scoreboard.
`timescale 1ns / 1ps
module frustum_sphere_cull_top_test;
   import fsc_pkg::*;

   localparam int CULL_PLANES    = FSC_NUM_PLANES;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RAND_PHASES    = 5;
   localparam int PHASE_REQUESTS = 360;
   localparam int EXTREME_REQS   = 200;
   localparam int MAX_HOLD       = 3;

   typedef logic signed [FSC_COORD_W-1:0] coord_type;
   typedef logic [FSC_RADIUS_W-1:0]       radius_type;
   typedef plane_type                     plane_set_type [FSC_PLANE_REGS];

   class cull_scoreboard;
      plane_type   planes[FSC_PLANE_REGS];
      bit          inside_q[$];
      int unsigned mismatches;
      int unsigned responses;

      function new();
         foreach (planes[i]) planes[i] = '0;
         mismatches = 0;
         responses  = 0;
      endfunction

      function void write_plane(int idx, plane_type value);
         if (idx < FSC_PLANE_REGS) planes[idx] = value;
      endfunction

      function bit sphere_visible(coord_type cx, coord_type cy, coord_type cz, radius_type r);
         longint nx, ny, nz, offs, px, py, pz, rad, distance;
         bit     visible;
         visible = 1'b1;
         px  = cx;
         py  = cy;
         pz  = cz;
         rad = r;
         for (int i = 0; i < CULL_PLANES; i++) begin
            nx   = $signed(planes[i][FSC_NORM_W-1:0]);
            ny   = $signed(planes[i][2*FSC_NORM_W-1:FSC_NORM_W]);
            nz   = $signed(planes[i][3*FSC_NORM_W-1:2*FSC_NORM_W]);
            offs = $signed(planes[i][FSC_CSR_DATA_W-1:3*FSC_NORM_W]);
            distance = nx * px + ny * py + nz * pz + (offs <<< FSC_SCALE_SHIFT);
            if (distance < -(rad <<< FSC_SCALE_SHIFT)) visible = 1'b0;
         end
         return visible;
      endfunction

      function void note_sphere(coord_type cx, coord_type cy, coord_type cz, radius_type r);
         inside_q.push_back(sphere_visible(cx, cy, cz, r));
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_inside(logic got);
         bit want;
         responses++;
         if (inside_q.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding", responses));
         end else begin
            want = inside_q.pop_front();
            if (got !== want)
               report($sformatf("response %0d: inside_res %b, expected %b",
                                responses, got, want));
         end
      endtask

      function int pending();
         return inside_q.size();
      endfunction
   endclass

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   coord_type  req_center_x   = '0;
   coord_type  req_center_y   = '0;
   coord_type  req_center_z   = '0;
   radius_type req_radius     = '0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic       rsp_inside_res;
   logic       csr_wen        = 1'b0;
   logic [FSC_CSR_IDX_W-1:0]  csr_index = '0;
   logic [FSC_CSR_DATA_W-1:0] csr_wdata = '0;

   cull_scoreboard sb;
   bit req_gaps_on   = 1'b0;
   bit rsp_stalls_on = 1'b0;
   int box_half      = 2048;
   int cycles        = 0;

   frustum_sphere_cull_top #(.NUM_PLANES(CULL_PLANES)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_center_z   (req_center_z),
      .req_radius     (req_radius),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_inside_res (rsp_inside_res),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_inside(rsp_inside_res);
         if (req_valid && !req_stall)
            sb.note_sphere(req_center_x, req_center_y, req_center_z, req_radius);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int hold;
      forever begin
         hold = rsp_stalls_on ? $urandom_range(0, MAX_HOLD) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   function automatic plane_type pack_plane(int nx, int ny, int nz, int offs);
      plane_type p;
      p = {offs[FSC_OFFS_W-1:0], nz[FSC_NORM_W-1:0], ny[FSC_NORM_W-1:0],
           nx[FSC_NORM_W-1:0]};
      return p;
   endfunction

   function automatic plane_set_type box_planes(int h);
      plane_set_type ps;
      ps[PLANE_NEAR_IDX]   = pack_plane(0, 0, 1024, h);
      ps[PLANE_FAR_IDX]    = pack_plane(0, 0, -1024, h);
      ps[PLANE_LEFT_IDX]   = pack_plane(1024, 0, 0, h);
      ps[PLANE_RIGHT_IDX]  = pack_plane(-1024, 0, 0, h);
      ps[PLANE_TOP_IDX]    = pack_plane(0, -1024, 0, h);
      ps[PLANE_BOTTOM_IDX] = pack_plane(0, 1024, 0, h);
      return ps;
   endfunction

   // indexes past the bottom plane get junk last, so an aliased decode shows up
   task automatic load_planes(input plane_set_type ps);
      plane_type data;
      for (int i = 0; i < 2**FSC_CSR_IDX_W; i++) begin
         data = (i <= PLANE_BOTTOM_IDX) ? ps[i] : {$urandom, $urandom};
         csr_wen   <= 1'b1;
         csr_index <= i[FSC_CSR_IDX_W-1:0];
         csr_wdata <= data;
         @(posedge clock);
         sb.write_plane(i, data);
      end
      csr_wen <= 1'b0;
   endtask

   task automatic send_sphere(input coord_type cx, input coord_type cy, input coord_type cz,
                              input radius_type r);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, MAX_HOLD) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_radius   <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      req_gaps_on   = mode[0];
      rsp_stalls_on = mode[1];
   endtask

   task automatic random_sphere(output coord_type cx, output coord_type cy,
                                output coord_type cz, output radius_type r);
      int mode, axis, bound, rad;
      int c[3];
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
         foreach (c[i]) c[i] = $urandom;
         rad = ($urandom_range(0, 3) == 0) ? 0 : $urandom;
      end else begin
         rad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, box_half);
         foreach (c[i]) c[i] = int'($urandom_range(0, 4 * box_half)) - 2 * box_half;
         // put one coordinate a radius beyond a face of the box, give or take one lsb
         if (mode >= 7) begin
            axis    = $urandom_range(0, 2);
            bound   = box_half + rad + int'($urandom_range(0, 2)) - 1;
            c[axis] = $urandom_range(0, 1) ? bound : -bound;
         end
      end
      cx = FSC_COORD_W'(c[0]);
      cy = FSC_COORD_W'(c[1]);
      cz = FSC_COORD_W'(c[2]);
      r  = FSC_RADIUS_W'(rad);
   endtask

   task automatic run_random(int count);
      coord_type  cx, cy, cz;
      radius_type r;
      repeat (count) begin
         random_sphere(cx, cy, cz, r);
         send_sphere(cx, cy, cz, r);
      end
      drain();
   endtask

   initial begin
      plane_set_type ps;
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // planes at reset value: everything reads as inside
      set_idling(0);
      send_sphere(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
      send_sphere(24'sh800000, 24'sh800000, 24'sh800000, 23'h000000);
      send_sphere(24'sh000000, 24'sh000000, 24'sh000000, 23'h000000);
      drain();

      // axis-aligned box, half size 8.0: faces, ties and extremes
      set_idling(3);
      box_half = 2048;
      load_planes(box_planes(box_half));
      send_sphere(0, 0, 0, 0);
      send_sphere(0, 0, -2048, 0);
      send_sphere(0, 0, -2049, 0);
      send_sphere(0, 0, -2304, 256);
      send_sphere(0, 0, -2305, 256);
      send_sphere(2148, 0, 0, 100);
      send_sphere(2149, 0, 0, 100);
      send_sphere(0, 24'sh800000, 0, 23'h7FFFFF);
      send_sphere(0, 24'sh800000, 0, 0);
      send_sphere(24'sh7FFFFF, 0, 0, 0);
      drain();

      // extreme plane encodings, unnormalized
      set_idling(1);
      ps[PLANE_NEAR_IDX]   = pack_plane(2047, 2047, 2047, 28'h7FFFFFF);
      ps[PLANE_FAR_IDX]    = pack_plane(-2048, -2048, -2048, 28'h7FFFFFF);
      ps[PLANE_LEFT_IDX]   = '0;
      ps[PLANE_RIGHT_IDX]  = '1;
      ps[PLANE_TOP_IDX]    = pack_plane(-2048, 0, 0, 0);
      ps[PLANE_BOTTOM_IDX] = {$urandom, $urandom};
      load_planes(ps);
      box_half = 4096;
      send_sphere(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF);
      send_sphere(24'sh800000, 24'sh800000, 24'sh800000, 23'h7FFFFF);
      send_sphere(24'sh800000, 24'sh7FFFFF, 24'sh800000, 0);
      send_sphere(-1, -1, -1, 0);
      set_idling(3);
      run_random(EXTREME_REQS);

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         set_idling(ph % 4);
         case (ph % 3)
            0: begin
               box_half = $urandom_range(64, 1 << 20);
               ps = box_planes(box_half);
            end
            1: begin
               box_half = $urandom_range(256, 8192);
               foreach (ps[i])
                  ps[i] = pack_plane(int'($urandom_range(0, 4095)) - 2048,
                                     int'($urandom_range(0, 4095)) - 2048,
                                     int'($urandom_range(0, 4095)) - 2048,
                                     int'($urandom_range(0, 9 * box_half / 4)) - box_half / 4);
            end
            default: begin
               box_half = 4096;
               foreach (ps[i]) ps[i] = {$urandom, $urandom};
            end
         endcase
         load_planes(ps);
         run_random(PHASE_REQUESTS);
      end

      repeat (2 * CULL_PLANES + 4) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d requests never got a response", sb.pending()));
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
